[rtl/core/ott_pkg.sv]
// Package for the one-shot timer table: request/response structs,
// command and status codes, slot memory entry and port types.
// No dependencies.
package ott_pkg;

   localparam int SLOT_IDX_W = 5;

   localparam logic [1:0] CMD_TICK   = 2'd0;
   localparam logic [1:0] CMD_CREATE = 2'd1;
   localparam logic [1:0] CMD_DELETE = 2'd2;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_BADARG = 2'd1;
   localparam logic [1:0] STATUS_FULL   = 2'd2;

   typedef struct packed {
      logic [1:0]            command;
      logic [31:0]           timeout;
      logic [15:0]           callback_tag;
      logic [31:0]           callback_arg;
      logic [SLOT_IDX_W-1:0] slot;
   } req_type;

   typedef struct packed {
      logic [1:0]            status;
      logic [SLOT_IDX_W-1:0] slot_index;
      logic                  fired;
      logic [15:0]           fired_tag;
      logic [31:0]           fired_arg;
   } rsp_type;

   // one slot of the timer memory
   typedef struct packed {
      logic [31:0] deadline;
      logic [15:0] tag;
      logic [31:0] arg;
   } entry_type;

   // slot memory port controls
   typedef struct packed {
      logic                  wr_en;
      logic [SLOT_IDX_W-1:0] wr_addr;
      logic                  rd_en;
      logic [SLOT_IDX_W-1:0] rd_addr;
   } ram_cmd_type;

endpackage

[rtl/core/ott_slot_ram.sv]
// Slot memory of the timer table: one write port, one read port,
// registered read data. Depends on ott_pkg.
module ott_slot_ram
   import ott_pkg::*;
#(
   parameter int DEPTH = 10
) (
   input  logic        clock,
   input  ram_cmd_type cmd,
   input  entry_type   wr_data,
   output entry_type   rd_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr[AW-1:0]] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cmd.rd_addr[AW-1:0]];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/one_shot_timer_table.sv]
// Top level of the one-shot timer table: command handling, tick counter,
// slot valid bits and the expiry scan over the slot memory.
// Depends on ott_pkg and ott_slot_ram.
//
//  channel   ports                       direction  transfer
//  -------   -------------------------   ---------  -------------------------------
//  request   start, busy, req_item       in         edge with start=1, busy=0
//  response  rsp_strobe, rsp_item        out        one cycle per request, no stall
//
// Create, delete and unknown commands: the response shows the cycle after
//   the request is taken, and busy stays low.
// A tick scans the slot memory one slot a cycle through its single read
//   port and stops at the first expired slot, or after the last slot when
//   none has expired.
// Reset: synchronous; clears the tick counter and all valid bits; slot memory
//   contents stay undefined and are only used behind a valid bit.
// The receiver cannot stall: each response is flagged by rsp_strobe for one cycle.
module one_shot_timer_table
   import ott_pkg::*;
#(
   parameter int NUM_SLOTS = 10
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
   localparam logic [CNT_W-1:0]      NUM_CNT  = CNT_W'(NUM_SLOTS);
   localparam logic [SLOT_W-1:0]     LAST_IDX = SLOT_W'(NUM_SLOTS - 1);
   localparam logic [SLOT_IDX_W:0]   NUM_REQ  = (SLOT_IDX_W + 1)'(NUM_SLOTS);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_SCAN = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic [31:0]          count_ff, count_in;
   logic [NUM_SLOTS-1:0] valid_ff, valid_in;
   // scan: issue pointer, and the slot whose read data lands this cycle
   logic [CNT_W-1:0]     issue_idx_ff, issue_idx_in;
   logic                 chk_vld_ff, chk_vld_in;
   logic [SLOT_W-1:0]    chk_idx_ff, chk_idx_in;
   logic                 strobe_ff, strobe_in;
   rsp_type              rsp_ff, rsp_in;

   ram_cmd_type ram_cmd;
   entry_type   ram_wr;
   entry_type   ram_rd;

   logic              accept;
   logic              bad_arg;
   logic              table_full;
   logic [SLOT_W-1:0] free_idx;
   logic              issue;
   logic              hit;
   logic              last_chk;

   ott_slot_ram #(
      .DEPTH(NUM_SLOTS)
   ) u_slot_ram (
      .clock  (clock),
      .cmd    (ram_cmd),
      .wr_data(ram_wr),
      .rd_data(ram_rd)
   );

   assign busy   = reset | (state_ff != S_IDLE);
   assign accept = start & ~busy;

   // lowest free slot
   always_comb begin
      free_idx = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = SLOT_W'(i);
         end
      end
   end

   assign table_full = &valid_ff;
   assign bad_arg    = (req_item.callback_tag == '0) || (req_item.timeout == '0);

   // expiry test on the slot read last cycle; counter already advanced
   assign hit      = chk_vld_ff && valid_ff[chk_idx_ff] && (count_ff >= ram_rd.deadline);
   assign last_chk = chk_vld_ff && (chk_idx_ff == LAST_IDX);
   assign issue    = (state_ff == S_SCAN) && (issue_idx_ff < NUM_CNT) && !hit;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      valid_in     = valid_ff;
      issue_idx_in = issue_idx_ff;
      chk_vld_in   = 1'b0;
      chk_idx_in   = chk_idx_ff;
      strobe_in    = 1'b0;
      rsp_in       = rsp_ff;

      ram_cmd.wr_en   = 1'b0;
      ram_cmd.wr_addr = SLOT_IDX_W'(free_idx);
      ram_cmd.rd_en   = issue;
      ram_cmd.rd_addr = SLOT_IDX_W'(issue_idx_ff[SLOT_W-1:0]);
      ram_wr.deadline = count_ff + req_item.timeout;
      ram_wr.tag      = req_item.callback_tag;
      ram_wr.arg      = req_item.callback_arg;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_in = '0;
               unique case (req_item.command)
                  CMD_TICK: begin
                     count_in     = count_ff + 32'd1;
                     issue_idx_in = '0;
                     state_in     = S_SCAN;
                  end
                  CMD_CREATE: begin
                     strobe_in = 1'b1;
                     if (bad_arg) begin
                        rsp_in.status = STATUS_BADARG;
                     end else if (table_full) begin
                        rsp_in.status = STATUS_FULL;
                     end else begin
                        ram_cmd.wr_en      = 1'b1;
                        valid_in[free_idx] = 1'b1;
                        rsp_in.slot_index  = SLOT_IDX_W'(free_idx);
                     end
                  end
                  CMD_DELETE: begin
                     strobe_in = 1'b1;
                     if ({1'b0, req_item.slot} < NUM_REQ) begin
                        valid_in[req_item.slot[SLOT_W-1:0]] = 1'b0;
                     end
                  end
                  default: begin
                     strobe_in = 1'b1;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (issue) begin
               issue_idx_in = issue_idx_ff + CNT_W'(1);
               chk_vld_in   = 1'b1;
               chk_idx_in   = issue_idx_ff[SLOT_W-1:0];
            end
            if (hit) begin
               valid_in[chk_idx_ff] = 1'b0;
               rsp_in.status        = STATUS_OK;
               rsp_in.slot_index    = SLOT_IDX_W'(chk_idx_ff);
               rsp_in.fired         = 1'b1;
               rsp_in.fired_tag     = ram_rd.tag;
               rsp_in.fired_arg     = ram_rd.arg;
            end
            if (hit || last_chk) begin
               chk_vld_in = 1'b0;
               strobe_in  = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         valid_ff     <= '0;
         issue_idx_ff <= '0;
         chk_vld_ff   <= 1'b0;
         strobe_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         valid_ff     <= valid_in;
         issue_idx_ff <= issue_idx_in;
         chk_vld_ff   <= chk_vld_in;
         strobe_ff    <= strobe_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      chk_idx_ff <= chk_idx_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

`ifndef ASSERT_OFF
   // a response is only ever shown with the block back at idle
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response strobe while busy");

   // a fired slot has its valid bit dropped when the response shows
   a_fire_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.fired) |-> !valid_ff[rsp_item.slot_index[SLOT_W-1:0]])
      else $error("fired slot still valid");

   // firing only on an ok status
   a_fire_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.fired) |-> (rsp_item.status == STATUS_OK))
      else $error("fired with non-ok status");

   // a taken tick starts a scan and bumps the counter
   a_tick_scan: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_item.command == CMD_TICK)) |=>
         (busy && (count_ff == $past(count_ff) + 32'd1)))
      else $error("tick did not start scan");

   // read data is only checked during a scan
   a_chk_in_scan: assert property (@(posedge clock) disable iff (reset)
      chk_vld_ff |-> (state_ff == S_SCAN))
      else $error("slot check outside scan");
`endif

endmodule

[dv/one_shot_timer_table_test.sv]
`timescale 1ns / 100ps
// Self-checking bench for one_shot_timer_table: a directed opening, then random
// requests in three sender-idle phases, all checked against a built-in predictor.
// Depends on ott_pkg and the one_shot_timer_table RTL.
module one_shot_timer_table_test;
   import ott_pkg::*;

   localparam int NUM_SLOTS = 10;
   // command code the block must treat as a no-op
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int PHASE_ITEMS = 284;
   // drain time after the last response, chosen to cover the longest tick scan
   localparam int DRAIN_CYCLES = NUM_SLOTS + 6;
   localparam int unsigned CYCLE_LIMIT = 400000;

   // Predicts the timer table and checks responses in request order.
   class timer_table_scoreboard #(int SLOTS = 10);
      logic [31:0] ticks_seen;
      logic        armed [SLOTS];
      logic [31:0] due_at [SLOTS];
      logic [15:0] handler_tag [SLOTS];
      logic [31:0] handler_arg [SLOTS];
      rsp_type     awaited_outcomes [$];
      int          response_count;
      int          mismatch_count;

      function new();
         ticks_seen = '0;
         foreach (armed[i]) armed[i] = 1'b0;
         response_count = 0;
         mismatch_count = 0;
      endfunction

      // Apply one accepted request to the predicted table, queue its outcome.
      function void note_request(req_type r);
         rsp_type outcome;
         bit      found;
         outcome = '0;
         found = 1'b0;
         case (r.command)
            CMD_TICK: begin
               // counter moves first, then the lowest expired slot fires
               ticks_seen = ticks_seen + 32'd1;
               for (int i = 0; i < SLOTS; i++) begin
                  if (!found && armed[i] && ticks_seen >= due_at[i]) begin
                     found = 1'b1;
                     armed[i] = 1'b0;
                     outcome.slot_index = SLOT_IDX_W'(i);
                     outcome.fired = 1'b1;
                     outcome.fired_tag = handler_tag[i];
                     outcome.fired_arg = handler_arg[i];
                  end
               end
            end
            CMD_CREATE: begin
               // argument check wins over the full check
               if (r.callback_tag == '0 || r.timeout == '0) begin
                  outcome.status = STATUS_BADARG;
               end else begin
                  for (int i = 0; i < SLOTS; i++) begin
                     if (!found && !armed[i]) begin
                        found = 1'b1;
                        armed[i] = 1'b1;
                        due_at[i] = ticks_seen + r.timeout;
                        handler_tag[i] = r.callback_tag;
                        handler_arg[i] = r.callback_arg;
                        outcome.slot_index = SLOT_IDX_W'(i);
                     end
                  end
                  if (!found) outcome.status = STATUS_FULL;
               end
            end
            CMD_DELETE: begin
               if (r.slot < SLOTS) armed[r.slot] = 1'b0;
            end
            default: ;
         endcase
         awaited_outcomes.push_back(outcome);
      endfunction

      task report_mismatch(string what);
         $display("MISMATCH at response %0d: %s", response_count, what);
         mismatch_count++;
      endtask

      task compare_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
      endtask

      task check_response(rsp_type got);
         rsp_type want;
         if (awaited_outcomes.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            want = awaited_outcomes.pop_front();
            compare_field("status", 32'(got.status), 32'(want.status));
            compare_field("slot_index", 32'(got.slot_index), 32'(want.slot_index));
            compare_field("fired", 32'(got.fired), 32'(want.fired));
            compare_field("fired_tag", 32'(got.fired_tag), 32'(want.fired_tag));
            compare_field("fired_arg", got.fired_arg, want.fired_arg);
            response_count++;
         end
      endtask
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_strobe;
   rsp_type rsp_item;

   timer_table_scoreboard #(NUM_SLOTS) tt_board;
   int unsigned cycle_count = 0;
   // percent chance per cycle that the sender holds off a request
   int unsigned idle_pct = 0;

   one_shot_timer_table #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Sample at the rising edge: the block's outputs still hold their
   // pre-edge values here, and our inputs only move on the falling edge.
   // A request is always noted at an earlier edge than its response, so
   // noting before checking keeps the queue in order.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (start && !busy) tt_board.note_request(req_item);
         if (rsp_strobe === 1'b1) tt_board.check_response(rsp_item);
      end
   end

   // Watchdog: a hung handshake or a lost response ends here.
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   function automatic req_type make_request(logic [1:0] cmd, logic [31:0] timeout,
                                            logic [15:0] tag, logic [31:0] arg,
                                            logic [SLOT_IDX_W-1:0] slot);
      req_type r;
      r.command = cmd;
      r.timeout = timeout;
      r.callback_tag = tag;
      r.callback_arg = arg;
      r.slot = slot;
      return r;
   endfunction

   // Mostly short timeouts so timers really expire; some zero, fully random
   // and near-max ones (the last wrap the deadline and fire at once).
   function automatic req_type random_request();
      req_type     r;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 42)      r.command = CMD_TICK;
      else if (pick < 77) r.command = CMD_CREATE;
      else if (pick < 93) r.command = CMD_DELETE;
      else                r.command = CMD_UNUSED;
      pick = $urandom_range(0, 99);
      if (pick < 65)      r.timeout = $urandom_range(1, 24);
      else if (pick < 75) r.timeout = '0;
      else if (pick < 88) r.timeout = $urandom;
      else                r.timeout = 32'hFFFF_FFFF - $urandom_range(0, 15);
      r.callback_tag = ($urandom_range(0, 99) < 8) ? 16'h0 : 16'($urandom_range(1, 65535));
      r.callback_arg = $urandom;
      // deletes mostly aim at real slots, sometimes past the end
      if ($urandom_range(0, 99) < 80)
         r.slot = SLOT_IDX_W'($urandom_range(0, NUM_SLOTS - 1));
      else
         r.slot = SLOT_IDX_W'($urandom_range(0, 31));
      return r;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   // start is assigned once per falling edge, so back-to-back requests keep
   // it high without a glitch.
   task automatic send_request(input req_type r);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_item <= r;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      int unsigned phase_idle [3];
      phase_idle = '{16, 78, 0};
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      tt_board = new();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // --- directed part ---
      // quiet tick on an empty table
      send_request(make_request(CMD_TICK, 32'd7, 16'h1234, 32'h0, 5'd0));
      // bad arguments: null tag, zero timeout, both
      send_request(make_request(CMD_CREATE, 32'd5, 16'h0, 32'h1, 5'd0));
      send_request(make_request(CMD_CREATE, 32'd0, 16'h5, 32'h2, 5'd0));
      send_request(make_request(CMD_CREATE, 32'd0, 16'h0, 32'h3, 5'd0));
      // extreme tag and argument, expires on the next tick
      send_request(make_request(CMD_CREATE, 32'd1, 16'hFFFF, 32'hFFFF_FFFF, 5'd31));
      send_request(make_request(CMD_TICK, 32'd0, 16'h0, 32'h0, 5'd0));
      // max timeout wraps the deadline just below the counter: fires at once
      send_request(make_request(CMD_CREATE, 32'hFFFF_FFFF, 16'h0001, 32'h0, 5'd0));
      send_request(make_request(CMD_TICK, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 5'd31));
      // fill every slot with far deadlines, then one more to hit table full
      for (int i = 0; i < NUM_SLOTS; i++)
         send_request(make_request(CMD_CREATE, 32'd1000 + i, 16'(16'h8000 >> i),
                                   32'hA5A5_0000 + i, 5'd0));
      send_request(make_request(CMD_CREATE, 32'd3, 16'h00FF, 32'hDEAD_BEEF, 5'd0));
      // deletes past the end are ignored
      send_request(make_request(CMD_DELETE, 32'd0, 16'h0, 32'h0, 5'd31));
      send_request(make_request(CMD_DELETE, 32'd0, 16'h0, 32'h0, 5'(NUM_SLOTS)));
      // delete a slot, then the same one again while free
      send_request(make_request(CMD_DELETE, 32'd0, 16'h0, 32'h0, 5'd3));
      send_request(make_request(CMD_DELETE, 32'd0, 16'h0, 32'h0, 5'd3));
      // unknown command changes nothing
      send_request(make_request(CMD_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 5'd31));
      // the freed slot is the one taken next
      send_request(make_request(CMD_CREATE, 32'd2, 16'h0042, 32'h0000_0042, 5'd0));

      // --- random part, three sender idle settings ---
      foreach (phase_idle[p]) begin
         idle_pct = phase_idle[p];
         repeat (PHASE_ITEMS) send_request(random_request());
      end
      start <= 1'b0;

      while (tt_board.awaited_outcomes.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (tt_board.mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

[sim.f]
rtl/core/ott_pkg.sv
rtl/core/ott_slot_ram.sv
rtl/core/one_shot_timer_table.sv
dv/one_shot_timer_table_test.sv
